[rtl/core/ata_pkg.sv]
// Shared types and constants for the ATA PIO LBA28 transfer sequencer.
// Holds the item, result and batch structs, the phase enum and task-file codes.
// Depends on nothing; ata_step, ata_res_queue and the top level import it.
package ata_pkg;

    localparam int WORDS_PER_SECTOR = 256;
    localparam int WI_W             = $clog2(WORDS_PER_SECTOR) + 1;

    localparam int MAX_RES = 7;
    localparam int CNT_W   = 3;
    localparam int IDX_W   = 3;

    localparam int          POLL_W     = 20;
    localparam logic [19:0] POLL_RESET = 20'd100000;

    localparam logic [3:0] PORT_DATA       = 4'd0;
    localparam logic [3:0] PORT_ERROR      = 4'd1;
    localparam logic [3:0] PORT_COUNT      = 4'd2;
    localparam logic [3:0] PORT_LBA_LO     = 4'd3;
    localparam logic [3:0] PORT_LBA_MID    = 4'd4;
    localparam logic [3:0] PORT_LBA_HI     = 4'd5;
    localparam logic [3:0] PORT_DRV_HEAD   = 4'd6;
    localparam logic [3:0] PORT_STATUS_CMD = 4'd7;
    localparam logic [3:0] PORT_ALT_STATUS = 4'd8;

    localparam int ST_BSY_BIT = 7;
    localparam int ST_DRQ_BIT = 3;
    localparam int ST_ERR_BIT = 0;

    localparam logic [7:0] CMD_READ      = 8'h20;
    localparam logic [7:0] CMD_WRITE     = 8'h30;
    localparam logic [7:0] DRV_HEAD_BASE = 8'hE0;
    localparam logic [2:0] DELAY_COUNT   = 3'd4;

    typedef enum logic [1:0] {
        MODE_START_RD  = 2'd0,
        MODE_START_WR  = 2'd1,
        MODE_BUS_RSP   = 2'd2,
        MODE_HOST_WORD = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        KIND_BUS_RD    = 3'd0,
        KIND_BUS_WR    = 3'd1,
        KIND_HOST_WORD = 3'd2,
        KIND_DONE      = 3'd3,
        KIND_WR_READY  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        OUT_OK      = 2'd0,
        OUT_DEV_ERR = 2'd1,
        OUT_TIMEOUT = 2'd2
    } t_outcome;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_PRE_DELAY  = 4'd1,
        PH_PRE_BUSY   = 4'd2,
        PH_SEC_DELAY  = 4'd3,
        PH_SEC_BUSY   = 4'd4,
        PH_DRQ_READ   = 4'd5,
        PH_ERR_REG    = 4'd6,
        PH_DATA_READ  = 4'd7,
        PH_DRQ_WRITE  = 4'd8,
        PH_HOST_WORDS = 4'd9
    } t_phase;

    typedef struct packed {
        t_mode       mode;
        logic [27:0] lba;
        logic [7:0]  sector_total;
        logic [15:0] data;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  port;
        logic [15:0] value;
        t_outcome    outcome;
        logic [7:0]  error_code;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0]           count;
        t_result [MAX_RES-1:0]      res;
    } t_batch;

endpackage

[rtl/core/ata_in_if.sv]
// Input channel of the sequencer: valid/ready handshake with one item payload.
// Standalone interface; no package dependency.
interface ata_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [27:0] lba;
    logic [7:0]  sector_total;
    logic [15:0] data;

    modport source (output valid, mode, lba, sector_total, data, input ready);
    modport sink   (input valid, mode, lba, sector_total, data, output ready);
endinterface

[rtl/core/ata_out_if.sv]
// Result channel of the sequencer: valid/ready handshake with one result payload.
// Standalone interface; no package dependency.
interface ata_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [3:0]  port;
    logic [15:0] value;
    logic [1:0]  outcome;
    logic [7:0]  error_code;
    logic        last;

    modport source (output valid, kind, port, value, outcome, error_code, last, input ready);
    modport sink   (input valid, kind, port, value, outcome, error_code, last, output ready);
endinterface

[rtl/core/ata_step.sv]
// Transfer state machine: updates the sequencer state for each accepted item
// and builds the batch of results it causes. Holds the poll limit register.
// Depends on ata_pkg.
module ata_step
    import ata_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [POLL_W-1:0] i_cfg_wr_data,
    input  logic              i_accept,
    input  t_item             i_item,
    output t_batch            o_batch
);

    t_phase            r_phase, n_phase;
    logic              r_is_write, n_is_write;
    logic [7:0]        r_sectors_left, n_sectors_left;
    logic [WI_W-1:0]   r_word_index, n_word_index;
    logic [POLL_W-1:0] r_polls_done, n_polls_done;
    logic [2:0]        r_delay_reads, n_delay_reads;
    logic [27:0]       r_saved_lba, n_saved_lba;
    logic [POLL_W-1:0] r_poll_limit;

    logic [7:0]        st;
    logic [WI_W-1:0]   wi_inc;
    logic              sector_end;
    logic [7:0]        sl_dec;
    logic [POLL_W-1:0] polls_inc;
    logic [POLL_W-1:0] lim;
    t_result           wait_res;
    t_phase            wait_phase;

    function automatic t_result res_make(t_kind k, logic [3:0] p, logic [15:0] v,
                                         t_outcome o, logic [7:0] e);
        t_result r;
        r.kind       = k;
        r.port       = p;
        r.value      = v;
        r.outcome    = o;
        r.error_code = e;
        return r;
    endfunction

    function automatic t_result res_rd(logic [3:0] p);
        return res_make(KIND_BUS_RD, p, 16'h0000, OUT_OK, 8'h00);
    endfunction

    function automatic t_result res_wr(logic [3:0] p, logic [15:0] v);
        return res_make(KIND_BUS_WR, p, v, OUT_OK, 8'h00);
    endfunction

    function automatic t_result res_done(t_outcome o, logic [7:0] e);
        return res_make(KIND_DONE, PORT_DATA, 16'h0000, o, e);
    endfunction

    assign st        = i_item.data[7:0];
    assign wi_inc    = r_word_index + WI_W'(1);
    assign sector_end = (wi_inc >= WI_W'(WORDS_PER_SECTOR));
    assign sl_dec    = r_sectors_left - 8'd1;
    assign polls_inc = r_polls_done + POLL_W'(1);
    assign lim       = (r_poll_limit == '0) ? POLL_W'(1) : r_poll_limit;

    // The access that opens the wait for the next sector differs by direction.
    assign wait_res   = r_is_write ? res_rd(PORT_STATUS_CMD) : res_rd(PORT_ALT_STATUS);
    assign wait_phase = r_is_write ? PH_DRQ_WRITE : PH_SEC_DELAY;

    always_comb begin
        n_phase        = r_phase;
        n_is_write     = r_is_write;
        n_sectors_left = r_sectors_left;
        n_word_index   = r_word_index;
        n_polls_done   = r_polls_done;
        n_delay_reads  = r_delay_reads;
        n_saved_lba    = r_saved_lba;
        o_batch        = '0;

        case (i_item.mode)
            MODE_START_RD, MODE_START_WR: begin
                if (r_phase == PH_IDLE) begin
                    if (i_item.sector_total == 8'd0) begin
                        o_batch.res[0] = res_done(OUT_OK, 8'h00);
                        o_batch.count  = CNT_W'(1);
                    end else begin
                        n_is_write     = (i_item.mode == MODE_START_WR);
                        n_saved_lba    = i_item.lba;
                        n_sectors_left = i_item.sector_total;
                        n_word_index   = '0;
                        n_polls_done   = '0;
                        n_delay_reads  = 3'd1;
                        n_phase        = PH_PRE_DELAY;
                        o_batch.res[0] = res_rd(PORT_ALT_STATUS);
                        o_batch.count  = CNT_W'(1);
                    end
                end
            end
            MODE_BUS_RSP: begin
                case (r_phase)
                    PH_PRE_DELAY, PH_SEC_DELAY: begin
                        o_batch.count = CNT_W'(1);
                        if (r_delay_reads < DELAY_COUNT) begin
                            n_delay_reads  = r_delay_reads + 3'd1;
                            o_batch.res[0] = res_rd(PORT_ALT_STATUS);
                        end else begin
                            n_phase = (r_phase == PH_PRE_DELAY) ? PH_PRE_BUSY : PH_SEC_BUSY;
                            o_batch.res[0] = res_rd(PORT_STATUS_CMD);
                        end
                    end
                    PH_PRE_BUSY: begin
                        if (st[ST_BSY_BIT]) begin
                            o_batch.res[0] = res_rd(PORT_STATUS_CMD);
                            o_batch.count  = CNT_W'(1);
                        end else begin
                            // Load the task file, issue the command, then wait.
                            o_batch.res[0] = res_wr(PORT_DRV_HEAD,
                                {8'h00, DRV_HEAD_BASE | {4'h0, r_saved_lba[27:24]}});
                            o_batch.res[1] = res_wr(PORT_COUNT, {8'h00, r_sectors_left});
                            o_batch.res[2] = res_wr(PORT_LBA_LO, {8'h00, r_saved_lba[7:0]});
                            o_batch.res[3] = res_wr(PORT_LBA_MID, {8'h00, r_saved_lba[15:8]});
                            o_batch.res[4] = res_wr(PORT_LBA_HI, {8'h00, r_saved_lba[23:16]});
                            o_batch.res[5] = res_wr(PORT_STATUS_CMD,
                                {8'h00, r_is_write ? CMD_WRITE : CMD_READ});
                            o_batch.res[6] = wait_res;
                            o_batch.count  = CNT_W'(7);
                            n_word_index   = '0;
                            n_phase        = wait_phase;
                            if (!r_is_write) begin
                                n_delay_reads = 3'd1;
                            end
                        end
                    end
                    PH_SEC_BUSY: begin
                        o_batch.res[0] = res_rd(PORT_STATUS_CMD);
                        o_batch.count  = CNT_W'(1);
                        if (!st[ST_BSY_BIT]) begin
                            n_phase      = PH_DRQ_READ;
                            n_polls_done = '0;
                        end
                    end
                    PH_DRQ_READ: begin
                        o_batch.count = CNT_W'(1);
                        if (st[ST_ERR_BIT]) begin
                            n_phase        = PH_ERR_REG;
                            o_batch.res[0] = res_rd(PORT_ERROR);
                        end else begin
                            n_polls_done = polls_inc;
                            // DRQ wins over the poll count, so a late DRQ still proceeds.
                            if (st[ST_DRQ_BIT]) begin
                                n_phase        = PH_DATA_READ;
                                n_word_index   = '0;
                                o_batch.res[0] = res_rd(PORT_DATA);
                            end else if (polls_inc >= lim) begin
                                n_phase        = PH_IDLE;
                                o_batch.res[0] = res_done(OUT_TIMEOUT, 8'h00);
                            end else begin
                                o_batch.res[0] = res_rd(PORT_STATUS_CMD);
                            end
                        end
                    end
                    PH_ERR_REG: begin
                        n_phase        = PH_IDLE;
                        o_batch.res[0] = res_done(OUT_DEV_ERR, st);
                        o_batch.count  = CNT_W'(1);
                    end
                    PH_DATA_READ: begin
                        o_batch.res[0] = res_make(KIND_HOST_WORD, PORT_DATA, i_item.data,
                                                  OUT_OK, 8'h00);
                        o_batch.count  = CNT_W'(2);
                        n_word_index   = wi_inc;
                        if (!sector_end) begin
                            o_batch.res[1] = res_rd(PORT_DATA);
                        end else begin
                            n_sectors_left = sl_dec;
                            if (sl_dec == 8'd0) begin
                                n_phase        = PH_IDLE;
                                o_batch.res[1] = res_done(OUT_OK, 8'h00);
                            end else begin
                                o_batch.res[1] = wait_res;
                                n_word_index   = '0;
                                n_phase        = wait_phase;
                                n_delay_reads  = 3'd1;
                            end
                        end
                    end
                    PH_DRQ_WRITE: begin
                        o_batch.count = CNT_W'(1);
                        if (st[ST_DRQ_BIT]) begin
                            n_phase        = PH_HOST_WORDS;
                            n_word_index   = '0;
                            o_batch.res[0] = res_make(KIND_WR_READY, PORT_DATA, 16'h0000,
                                                      OUT_OK, 8'h00);
                        end else begin
                            o_batch.res[0] = res_rd(PORT_STATUS_CMD);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            MODE_HOST_WORD: begin
                if (r_phase == PH_HOST_WORDS) begin
                    o_batch.res[0] = res_wr(PORT_DATA, i_item.data);
                    o_batch.count  = CNT_W'(1);
                    n_word_index   = wi_inc;
                    if (sector_end) begin
                        n_sectors_left = sl_dec;
                        o_batch.count  = CNT_W'(2);
                        if (sl_dec == 8'd0) begin
                            n_phase        = PH_IDLE;
                            o_batch.res[1] = res_done(OUT_OK, 8'h00);
                        end else begin
                            o_batch.res[1] = wait_res;
                            n_word_index   = '0;
                            n_phase        = wait_phase;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_accept) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_write     <= 1'b0;
            r_sectors_left <= '0;
            r_word_index   <= '0;
            r_polls_done   <= '0;
            r_delay_reads  <= '0;
            r_saved_lba    <= '0;
        end else if (i_accept) begin
            r_is_write     <= n_is_write;
            r_sectors_left <= n_sectors_left;
            r_word_index   <= n_word_index;
            r_polls_done   <= n_polls_done;
            r_delay_reads  <= n_delay_reads;
            r_saved_lba    <= n_saved_lba;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= POLL_RESET;
        end else if (i_cfg_wr_en) begin
            r_poll_limit <= i_cfg_wr_data;
        end
    end

    // A running transfer always has at least one sector still to move.
    a_sectors_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_IDLE |-> r_sectors_left != 8'd0)
        else $error("transfer running with no sectors left");

    // After a completed sector the index may rest at the sector size while idle.
    a_word_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_IDLE |-> r_word_index < WI_W'(WORDS_PER_SECTOR))
        else $error("word index beyond sector size");

    a_delay_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PRE_DELAY || r_phase == PH_SEC_DELAY)
            |-> (r_delay_reads != 3'd0 && r_delay_reads <= DELAY_COUNT))
        else $error("delay read count out of range");

endmodule

[rtl/core/ata_res_queue.sv]
// Result queue: holds one item's batch of results and presents them one per cycle
// while o_res.ready is high, via an output register. Depends on ata_pkg, ata_out_if.
module ata_res_queue
    import ata_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_batch           i_batch,
    output logic             o_space,
    ata_out_if.source        o_res
);

    t_batch           r_batch;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_rd_idx;
    t_result          r_out;
    logic             r_out_last;
    logic             r_out_valid;

    logic             move;
    logic             move_last;

    assign move      = (r_count != '0) && (!r_out_valid || o_res.ready);
    assign move_last = (r_rd_idx == IDX_W'(r_count - CNT_W'(1)));
    // The next batch may enter once the current one has handed over its final result.
    assign o_space   = (r_count == '0) || (move && move_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_load) begin
                r_count  <= i_batch.count;
                r_rd_idx <= '0;
            end else if (move) begin
                if (move_last) begin
                    r_count  <= '0;
                    r_rd_idx <= '0;
                end else begin
                    r_rd_idx <= r_rd_idx + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_batch <= i_batch;
        end
        if (move) begin
            r_out      <= r_batch.res[r_rd_idx];
            r_out_last <= move_last;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.kind       = r_out.kind;
    assign o_res.port       = r_out.port;
    assign o_res.value      = r_out.value;
    assign o_res.outcome    = r_out.outcome;
    assign o_res.error_code = r_out.error_code;
    assign o_res.last       = r_out_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RES))
        else $error("result count beyond batch size");

    a_index_in_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 |-> r_rd_idx < IDX_W'(r_count))
        else $error("read index beyond batch");

    a_load_needs_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_space)
        else $error("batch loaded over unsent results");

    a_move_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> r_out_valid)
        else $error("result moved but output register empty");

endmodule

[rtl/core/ata_pio_lba28_transfer_sequencer_core.sv]
// Top level of the host-side ATA PIO LBA28 transfer sequencer.
// Joins the transfer state machine and the result queue.
// Depends on ata_pkg, ata_in_if, ata_out_if, ata_step and ata_res_queue.
//
// Usage: items arrive on i_cmd: a start request (read or write, with LBA and
// sector count), the response to the single bus read that is outstanding, or
// one host data word for a write sector. Results leave on o_res: bus reads and
// writes of the task file, words for the host, a ready-for-sector notice and a
// completion with its outcome. Each item yields zero to seven results; the
// final result of an item carries last.
// The batch of an accepted item is registered in the result queue; its results
// pass through the output register one per cycle while o_res.ready is high.
// Throughput: one item per cycle while o_res.ready is high, for items with at
// most one result. An item with more results holds the result queue until the
// cycle its final result moves to the output register, when the next item is
// taken. The result queue holds one item's batch of results.
// Reset (synchronous, active low) puts the sequencer idle, clears all counters
// and sets the poll limit to 100000. If the receiver stalls, the output
// register holds its result, the queue holds the batch and i_cmd.ready falls
// once the queue is full; nothing is lost or repeated.
// The poll limit may be written through i_cfg_wr_en / i_cfg_wr_data while the
// block is idle.
module ata_pio_lba28_transfer_sequencer_core
    import ata_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [POLL_W-1:0] i_cfg_wr_data,
    ata_in_if.sink            i_cmd,
    ata_out_if.source         o_res
);

    t_item  item;
    t_batch batch;
    logic   space;
    logic   accept;

    // An item is taken whenever the queue can receive its batch of results.
    assign i_cmd.ready = space;
    assign accept      = i_cmd.valid && space;

    assign item.mode         = t_mode'(i_cmd.mode);
    assign item.lba          = i_cmd.lba;
    assign item.sector_total = i_cmd.sector_total;
    assign item.data         = i_cmd.data;

    ata_step u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_item        (item),
        .o_batch       (batch)
    );

    ata_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_batch (batch),
        .o_space (space),
        .o_res   (o_res)
    );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for the ATA PIO LBA28 transfer sequencer core.
// Uses ata_pkg, ata_in_if and ata_out_if. A built-in predictor checks every result in order.
module tb;
    import ata_pkg::*;

    // Predicted sequencer state, one copy for the stimulus planner and one for the checker.
    typedef struct packed {
        t_phase      phase;
        logic        is_wr;
        logic [7:0]  sect_left;
        logic [8:0]  word_idx;
        logic [19:0] polls;
        logic [2:0]  delays;
        logic [27:0] lba;
    } t_seq_state;

    typedef struct packed {
        t_result r;
        logic    last;
    } t_due_result;

    typedef struct packed {
        logic [2:0]                n;
        t_due_result [MAX_RES-1:0] e;
    } t_result_batch;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [POLL_W-1:0] cfg_wr_data = '0;

    logic  cmd_valid = 1'b0;
    t_item cmd_item = '0;
    logic  res_ready = 1'b0;

    ata_in_if  cmd_if ();
    ata_out_if res_if ();

    assign cmd_if.valid        = cmd_valid;
    assign cmd_if.mode         = cmd_item.mode;
    assign cmd_if.lba          = cmd_item.lba;
    assign cmd_if.sector_total = cmd_item.sector_total;
    assign cmd_if.data         = cmd_item.data;
    assign res_if.ready        = res_ready;

    ata_pio_lba28_transfer_sequencer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_cmd         (cmd_if.sink),
        .o_res         (res_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_item       items_to_send [$];
    t_due_result results_due [$];
    t_seq_state  plan_state = '0;
    t_seq_state  check_state = '0;
    logic [19:0] poll_limit_cfg = POLL_RESET;
    int          tx_idle_max = 5;
    int          rx_idle_max = 5;
    int unsigned fail_count = 0;
    int unsigned results_seen = 0;
    bit          hold_arm = 1'b0;
    logic        rx_hold = 1'b0;

    function automatic t_result_batch add_result(t_result_batch b, t_kind k, logic [3:0] p,
                                                 logic [15:0] v, t_outcome o = OUT_OK,
                                                 logic [7:0] ec = 8'h00);
        t_result_batch nb;
        nb = b;
        nb.e[nb.n].r.kind       = k;
        nb.e[nb.n].r.port       = p;
        nb.e[nb.n].r.value      = v;
        nb.e[nb.n].r.outcome    = o;
        nb.e[nb.n].r.error_code = ec;
        nb.e[nb.n].last         = 1'b0;
        nb.n = nb.n + 3'd1;
        return nb;
    endfunction

    // Works out the next sequencer state and the results that one accepted item causes.
    function automatic void sequencer_next(input t_seq_state s, input t_item it,
                                           input logic [19:0] lim_reg,
                                           output t_seq_state ns, output t_result_batch b);
        logic [7:0]  st;
        logic [19:0] lim;
        bit          open_sector;
        ns = s;
        b = '0;
        st = it.data[7:0];
        lim = (lim_reg == '0) ? 20'd1 : lim_reg;
        open_sector = 1'b0;
        case (it.mode)
            MODE_START_RD, MODE_START_WR: begin
                if (s.phase == PH_IDLE) begin
                    if (it.sector_total == 8'd0) begin
                        b = add_result(b, KIND_DONE, '0, '0, OUT_OK);
                    end else begin
                        ns.is_wr = (it.mode == MODE_START_WR);
                        ns.lba = it.lba;
                        ns.sect_left = it.sector_total;
                        ns.word_idx = '0;
                        ns.polls = '0;
                        ns.delays = 3'd1;
                        ns.phase = PH_PRE_DELAY;
                        b = add_result(b, KIND_BUS_RD, PORT_ALT_STATUS, '0);
                    end
                end
            end
            MODE_BUS_RSP: begin
                case (s.phase)
                    PH_PRE_DELAY, PH_SEC_DELAY: begin
                        if (s.delays < DELAY_COUNT) begin
                            ns.delays = s.delays + 3'd1;
                            b = add_result(b, KIND_BUS_RD, PORT_ALT_STATUS, '0);
                        end else begin
                            ns.phase = (s.phase == PH_PRE_DELAY) ? PH_PRE_BUSY : PH_SEC_BUSY;
                            b = add_result(b, KIND_BUS_RD, PORT_STATUS_CMD, '0);
                        end
                    end
                    PH_PRE_BUSY: begin
                        if (st[ST_BSY_BIT]) begin
                            b = add_result(b, KIND_BUS_RD, PORT_STATUS_CMD, '0);
                        end else begin
                            b = add_result(b, KIND_BUS_WR, PORT_DRV_HEAD,
                                           {8'h00, DRV_HEAD_BASE | {4'h0, s.lba[27:24]}});
                            b = add_result(b, KIND_BUS_WR, PORT_COUNT, {8'h00, s.sect_left});
                            b = add_result(b, KIND_BUS_WR, PORT_LBA_LO, {8'h00, s.lba[7:0]});
                            b = add_result(b, KIND_BUS_WR, PORT_LBA_MID, {8'h00, s.lba[15:8]});
                            b = add_result(b, KIND_BUS_WR, PORT_LBA_HI, {8'h00, s.lba[23:16]});
                            b = add_result(b, KIND_BUS_WR, PORT_STATUS_CMD,
                                           {8'h00, s.is_wr ? CMD_WRITE : CMD_READ});
                            open_sector = 1'b1;
                        end
                    end
                    PH_SEC_BUSY: begin
                        if (!st[ST_BSY_BIT]) begin
                            ns.phase = PH_DRQ_READ;
                            ns.polls = '0;
                        end
                        b = add_result(b, KIND_BUS_RD, PORT_STATUS_CMD, '0);
                    end
                    PH_DRQ_READ: begin
                        // ERR wins over DRQ; DRQ is honoured even on the last allowed poll.
                        if (st[ST_ERR_BIT]) begin
                            ns.phase = PH_ERR_REG;
                            b = add_result(b, KIND_BUS_RD, PORT_ERROR, '0);
                        end else begin
                            ns.polls = s.polls + 20'd1;
                            if (st[ST_DRQ_BIT]) begin
                                ns.phase = PH_DATA_READ;
                                ns.word_idx = '0;
                                b = add_result(b, KIND_BUS_RD, PORT_DATA, '0);
                            end else if (ns.polls >= lim) begin
                                ns.phase = PH_IDLE;
                                b = add_result(b, KIND_DONE, '0, '0, OUT_TIMEOUT);
                            end else begin
                                b = add_result(b, KIND_BUS_RD, PORT_STATUS_CMD, '0);
                            end
                        end
                    end
                    PH_ERR_REG: begin
                        ns.phase = PH_IDLE;
                        b = add_result(b, KIND_DONE, '0, '0, OUT_DEV_ERR, st);
                    end
                    PH_DATA_READ: begin
                        b = add_result(b, KIND_HOST_WORD, '0, it.data);
                        ns.word_idx = s.word_idx + 9'd1;
                        if (ns.word_idx < WORDS_PER_SECTOR) begin
                            b = add_result(b, KIND_BUS_RD, PORT_DATA, '0);
                        end else begin
                            ns.sect_left = s.sect_left - 8'd1;
                            if (ns.sect_left == 8'd0) begin
                                ns.phase = PH_IDLE;
                                b = add_result(b, KIND_DONE, '0, '0, OUT_OK);
                            end else begin
                                open_sector = 1'b1;
                            end
                        end
                    end
                    PH_DRQ_WRITE: begin
                        if (st[ST_DRQ_BIT]) begin
                            ns.phase = PH_HOST_WORDS;
                            ns.word_idx = '0;
                            b = add_result(b, KIND_WR_READY, '0, '0);
                        end else begin
                            b = add_result(b, KIND_BUS_RD, PORT_STATUS_CMD, '0);
                        end
                    end
                    default: ;
                endcase
            end
            default: begin
                if (s.phase == PH_HOST_WORDS) begin
                    b = add_result(b, KIND_BUS_WR, PORT_DATA, it.data);
                    ns.word_idx = s.word_idx + 9'd1;
                    if (ns.word_idx >= WORDS_PER_SECTOR) begin
                        ns.sect_left = s.sect_left - 8'd1;
                        if (ns.sect_left == 8'd0) begin
                            ns.phase = PH_IDLE;
                            b = add_result(b, KIND_DONE, '0, '0, OUT_OK);
                        end else begin
                            open_sector = 1'b1;
                        end
                    end
                end
            end
        endcase
        // The next sector opens with a DRQ poll on writes and with delay reads on reads.
        if (open_sector) begin
            ns.word_idx = '0;
            if (ns.is_wr) begin
                ns.phase = PH_DRQ_WRITE;
                b = add_result(b, KIND_BUS_RD, PORT_STATUS_CMD, '0);
            end else begin
                ns.phase = PH_SEC_DELAY;
                ns.delays = 3'd1;
                b = add_result(b, KIND_BUS_RD, PORT_ALT_STATUS, '0);
            end
        end
        if (b.n != 3'd0)
            b.e[b.n - 3'd1].last = 1'b1;
    endfunction

    function automatic t_item mk_item(t_mode m, logic [27:0] a, logic [7:0] n, logic [15:0] d);
        t_item it;
        it.mode = m;
        it.lba = a;
        it.sector_total = n;
        it.data = d;
        return it;
    endfunction

    // A plausible device answer for whatever the sequencer is waiting on. With no_data set,
    // a read DRQ poll never shows DRQ without ERR, so the transfer ends by an error or a timeout.
    function automatic t_item answer_for(t_seq_state s, bit clean, bit no_data);
        t_item it;
        int    pick;
        it = mk_item(MODE_BUS_RSP, 28'($urandom()), 8'($urandom()), 16'($urandom()));
        pick = $urandom_range(0, 9);
        case (s.phase)
            PH_HOST_WORDS: it.mode = MODE_HOST_WORD;
            PH_PRE_BUSY, PH_SEC_BUSY: it.data[ST_BSY_BIT] = !clean && (pick < 3);
            PH_DRQ_WRITE: it.data[ST_DRQ_BIT] = clean || (pick >= 3);
            PH_DRQ_READ: begin
                if (no_data) begin
                    if (pick < 3) begin
                        it.data[ST_ERR_BIT] = 1'b1;
                    end else begin
                        it.data[ST_ERR_BIT] = 1'b0;
                        it.data[ST_DRQ_BIT] = 1'b0;
                    end
                end else if (clean || pick >= 5) begin
                    it.data[ST_ERR_BIT] = 1'b0;
                    it.data[ST_DRQ_BIT] = 1'b1;
                end else if (pick >= 2) begin
                    it.data[ST_ERR_BIT] = 1'b0;
                    it.data[ST_DRQ_BIT] = 1'b0;
                end else begin
                    it.data[ST_ERR_BIT] = 1'b1;
                end
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic queue_item(t_item it);
        t_seq_state    nx;
        t_result_batch unused;
        sequencer_next(plan_state, it, poll_limit_cfg, nx, unused);
        plan_state = nx;
        items_to_send.push_back(it);
    endtask

    // One transfer from its start item to its completion, with stray items mixed in unless clean.
    task automatic plan_transfer(bit wr, logic [27:0] lba, logic [7:0] total, bit clean,
                                 bit no_data);
        t_item stray;
        queue_item(mk_item(wr ? MODE_START_WR : MODE_START_RD, lba, total, 16'($urandom())));
        while (plan_state.phase != PH_IDLE) begin
            if (!clean && $urandom_range(0, 19) == 0) begin
                stray = mk_item(MODE_START_RD, 28'($urandom()), 8'($urandom()),
                                16'($urandom()));
                case ($urandom_range(0, 2))
                    0: stray.mode = MODE_START_RD;
                    1: stray.mode = MODE_START_WR;
                    default: stray.mode = (plan_state.phase == PH_HOST_WORDS) ?
                                          MODE_BUS_RSP : MODE_HOST_WORD;
                endcase
                queue_item(stray);
            end
            queue_item(answer_for(plan_state, clean, no_data));
        end
    endtask

    // Opens a transfer and carries it into its data words, then sends a few of them.
    task automatic plan_open(bit wr, logic [27:0] lba, int words);
        t_phase goal;
        goal = wr ? PH_HOST_WORDS : PH_DATA_READ;
        queue_item(mk_item(wr ? MODE_START_WR : MODE_START_RD, lba, 8'd2, 16'($urandom())));
        while (plan_state.phase != goal)
            queue_item(answer_for(plan_state, 1'b1, 1'b0));
        repeat (words) queue_item(answer_for(plan_state, 1'b1, 1'b0));
    endtask

    function automatic logic [7:0] random_total();
        int pick;
        pick = $urandom_range(0, 9);
        return (pick == 0) ? 8'd0 : (pick < 8) ? 8'd1 : 8'd2;
    endfunction

    // Waits until every item is taken and every result has arrived, plus a short tail.
    task automatic settle();
        do
            @(negedge i_clk);
        while (items_to_send.size() != 0 || cmd_valid || results_due.size() != 0);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic set_poll_limit(logic [19:0] v);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        poll_limit_cfg = v;
    endtask

    // Short transfers only: reads that end by an error or a timeout, and empty starts.
    task automatic random_phase(logic [19:0] lim, int tx_max, int rx_max, int transfers);
        logic [7:0] total;
        bit         wr;
        set_poll_limit(lim);
        tx_idle_max = tx_max;
        rx_idle_max = rx_max;
        repeat (transfers) begin
            total = random_total();
            wr = (total == 8'd0) && ($urandom_range(0, 1) == 1);
            plan_transfer(wr, 28'($urandom()), total, 1'b0, 1'b1);
        end
        settle();
    endtask

    // Sender: offers items from the pending queue with a random gap before each.
    always @(posedge i_clk) begin : sender
        t_seq_state    nx;
        t_result_batch b;
        int            k;
        int            tx_wait;
        bit            taken;
        logic          nv;
        if (!i_rst_n) begin
            cmd_valid <= 1'b0;
            tx_wait = 0;
            check_state = '0;
        end else begin
            taken = cmd_valid && cmd_if.ready;
            if (taken) begin
                sequencer_next(check_state, cmd_item, poll_limit_cfg, nx, b);
                check_state = nx;
                for (k = 0; k < b.n; k++)
                    results_due.push_back(b.e[k]);
            end
            if (!cmd_valid || taken) begin
                nv = 1'b0;
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (items_to_send.size() != 0) begin
                    cmd_item <= items_to_send.pop_front();
                    nv = 1'b1;
                    tx_wait = $urandom_range(0, tx_idle_max);
                end
                cmd_valid <= nv;
            end
        end
    end

    // Receiver: checks each taken result against the oldest prediction, then may stall.
    always @(posedge i_clk) begin : receiver
        t_due_result want;
        int          rx_wait;
        if (!i_rst_n) begin
            res_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (res_if.valid && res_ready) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    if (fail_count < 10)
                        $display("result %0d unexpected: kind=%0d port=%0d value=%h last=%b",
                                 results_seen, res_if.kind, res_if.port, res_if.value,
                                 res_if.last);
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    if (res_if.kind !== want.r.kind || res_if.port !== want.r.port ||
                        res_if.value !== want.r.value || res_if.outcome !== want.r.outcome ||
                        res_if.error_code !== want.r.error_code || res_if.last !== want.last)
                    begin
                        if (fail_count < 10) begin
                            $display({"result %0d expected kind=%0d port=%0d value=%h",
                                      " out=%0d err=%h last=%b"},
                                     results_seen, want.r.kind, want.r.port, want.r.value,
                                     want.r.outcome, want.r.error_code, want.last);
                            $display({"result %0d actual   kind=%0d port=%0d value=%h",
                                      " out=%0d err=%h last=%b"},
                                     results_seen, res_if.kind, res_if.port, res_if.value,
                                     res_if.outcome, res_if.error_code, res_if.last);
                        end
                        fail_count++;
                    end
                end
                rx_wait = $urandom_range(0, rx_idle_max);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            res_ready <= (rx_wait == 0) && !rx_hold;
        end
    end

    // Long receiver stall so that the result queue fills and the input backs up.
    initial begin : rx_pressure
        wait (hold_arm);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin : watchdog
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset poll limit.
        queue_item(mk_item(MODE_START_RD, 28'h0000000, 8'd0, 16'h0000));   // empty read
        queue_item(mk_item(MODE_START_WR, 28'hFFFFFFF, 8'd0, 16'hFFFF));   // empty write
        queue_item(mk_item(MODE_BUS_RSP, 28'hFFFFFFF, 8'hFF, 16'hFFFF));   // nothing outstanding
        queue_item(mk_item(MODE_HOST_WORD, 28'h0000000, 8'h00, 16'hFFFF)); // no sector open
        queue_item(mk_item(MODE_START_RD, 28'hFFFFFFF, 8'hFF, 16'h0000));
        queue_item(mk_item(MODE_START_WR, 28'h5A5A5A5, 8'd1, 16'h0000));   // busy, ignored
        queue_item(mk_item(MODE_HOST_WORD, 28'h0000000, 8'd0, 16'h1234));  // not awaited
        repeat (3) queue_item(mk_item(MODE_BUS_RSP, 28'h0, 8'd0, 16'hFFFF));
        queue_item(mk_item(MODE_BUS_RSP, 28'h0, 8'd0, 16'h0000));
        queue_item(mk_item(MODE_BUS_RSP, 28'h0, 8'd0, 16'h0080));          // still busy
        queue_item(mk_item(MODE_BUS_RSP, 28'h0, 8'd0, 16'hFF7F));          // task file setup
        repeat (4) queue_item(mk_item(MODE_BUS_RSP, 28'h0, 8'd0, 16'h0000));
        queue_item(mk_item(MODE_BUS_RSP, 28'h0, 8'd0, 16'h0080));
        queue_item(mk_item(MODE_BUS_RSP, 28'h0, 8'd0, 16'h0000));
        queue_item(mk_item(MODE_BUS_RSP, 28'h0, 8'd0, 16'h0009));          // ERR beats DRQ
        queue_item(mk_item(MODE_BUS_RSP, 28'h0, 8'd0, 16'hFFFF));          // error register
        settle();

        random_phase(20'd0, 5, 5, 1);
        random_phase(20'd3, 0, 5, 2);
        random_phase(20'($urandom_range(2, 6)), 5, 0, 1);

        // A write carried into its data words with no idling, under a long receiver stall.
        // The transfer is left open at the end of the run.
        set_poll_limit(20'hFFFFF);
        tx_idle_max = 0;
        rx_idle_max = 0;
        hold_arm = 1'b1;
        plan_open(1'b1, 28'($urandom()), 12);
        settle();

        if (fail_count == 0 && results_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
